// ===== sv/thg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Terrain height generator package
// Shared widths, phase and hash constants, and the quarter-wave sine table.
// ----------------------------------------------------------------------------
package thg_pkg;

	localparam int COLUMN_BITS     = 24;
	localparam int SINE_TABLE_BITS = 10;
	localparam int QSIZE           = 1 << SINE_TABLE_BITS;
	localparam int ADDR_W          = SINE_TABLE_BITS + 1;
	localparam int SINE_W          = 15;
	localparam int TERM_W          = 21;
	localparam int SUM_W           = 23;
	localparam int ROW_W           = 9;
	localparam int ROW_CALC_W      = 11;
	localparam int NUM_TERMS       = 3;
	localparam int FRAC_SHIFT      = 15;

	localparam logic [31:0] SEED_DEFAULT = 32'h9E3779B9;
	localparam logic [31:0] MIX_K1       = 32'h7FEB352D;
	localparam logic [31:0] MIX_K2       = 32'h846CA68B;

	// Phase step per column and phase offset, both in turns as 32-bit fractions.
	localparam logic [31:0] PHASE_INC [NUM_TERMS] = '{32'd18456262, 32'd8954705, 32'd56735918};
	localparam logic [31:0] PHASE_OFF [NUM_TERMS] = '{32'd0, 32'd1162060968, 32'd273426110};
	localparam logic [5:0]  AMP       [NUM_TERMS] = '{6'd34, 6'd20, 6'd7};

	localparam int ROW_BASE = 340;
	localparam int ROW_MIN  = 240;
	localparam int ROW_MAX  = 448;

	typedef logic [SINE_W-1:0] sine_tab_t [QSIZE+1];

	// Polynomial sine over the first quarter wave, Q0.15, evaluated at elaboration.
	function automatic sine_tab_t build_sine_tab();
		sine_tab_t   tab;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		for (int k = 0; k <= QSIZE; k++) begin
			x  = 64'(k) << (16 - SINE_TABLE_BITS);
			x2 = (x * x) >> 16;
			t  = 64'd5026995 - ((x2 * 64'd172272) >> 16);
			t  = 64'd85569306 - ((x2 * t) >> 16);
			t  = 64'd693598668 - ((x2 * t) >> 16);
			t  = 64'd1686629713 - ((x2 * t) >> 16);
			s  = (x * t) >> 16;
			s  = (s + 64'd16384) >> 15;
			if (s > 64'd32767) begin
				s = 64'd32767;
			end
			tab[k] = SINE_W'(s);
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

// ===== sv/thg_sine_rom.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quarter-wave sine ROM
// One read port with registered data; the read advances only when enabled.
// ----------------------------------------------------------------------------
module thg_sine_rom (
	input  logic                        clk,
	input  logic                        en,
	input  logic [thg_pkg::ADDR_W-1:0]  addr,
	output logic [thg_pkg::SINE_W-1:0]  data
);

	always_ff @(posedge clk) begin
		if (en) begin
			data <= thg_pkg::SINE_TAB[addr];
		end
	end

endmodule

// ===== sv/terrain_height_generator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Terrain height generator
// Maps a signed world column to the screen row of the terrain top.
// ----------------------------------------------------------------------------
// The block takes one column per clock while the output is not stalled and
// returns one row per column, in order. Each column passes through the
// six-stage pipeline: column magnitude, phase multipliers, phase to table
// address, sine ROM read, weighted sum, and row clamp. Each sine term has its
// own copy of the 1025-entry quarter-wave ROM.
// The seed register takes a write beat in any cycle and should only be
// written while no columns are in flight; writing zero selects the default
// seed.
module terrain_height_generator_top (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [thg_pkg::COLUMN_BITS-1:0]  world_column,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [thg_pkg::ROW_W-1:0]               ground_top_row,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [31:0]                             seed
);

	localparam int CB = thg_pkg::COLUMN_BITS;
	localparam int NT = thg_pkg::NUM_TERMS;

	logic [31:0] seed_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;

	logic [CB-1:0]                col_raw;
	logic [CB-1:0]                col_mag;
	logic [31:0]                  hash_in;
	logic [CB-1:0]                c_s1;
	logic [31:0]                  hpre_s1;
	logic [31:0]                  prod_s2 [NT];
	logic [31:0]                  hmul_s2;
	logic [31:0]                  hmix;
	logic [thg_pkg::ADDR_W-1:0]   addr_s3 [NT];
	logic [NT-1:0]                neg_s3;
	logic [31:0]                  hmul_s3;
	logic [31:0]                  hfin;
	logic [thg_pkg::SINE_W-1:0]   sine_s4 [NT];
	logic [NT-1:0]                neg_s4;
	logic [16:0]                  fold_s4;
	logic signed [thg_pkg::SUM_W-1:0] sum_s5;
	logic [2:0]                   rem_s5;
	logic [thg_pkg::ROW_W-1:0]    row_s6;

	// Configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= thg_pkg::SEED_DEFAULT;
		end else if (cfg_valid && cfg_ready) begin
			seed_q <= (seed == 32'd0) ? thg_pkg::SEED_DEFAULT : seed;
		end
	end

	// A stage loads when it is empty or its contents move on this cycle.
	assign en6 = !v_s6 || out_ready;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	// Stage 1: column magnitude and first hash mixing step.
	always_comb begin
		col_raw = world_column;
		col_mag = col_raw[CB-1] ? CB'(~col_raw + 1'b1) : col_raw;
		hash_in = 32'(col_mag) ^ seed_q;
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			c_s1    <= col_mag;
			hpre_s1 <= hash_in ^ (hash_in >> 16);
		end
	end

	// Stage 2: phase products and first hash multiply.
	always_ff @(posedge clk) begin
		if (en2) begin
			for (int k = 0; k < NT; k++) begin
				prod_s2[k] <= 32'(c_s1) * thg_pkg::PHASE_INC[k];
			end
			hmul_s2 <= hpre_s1 * thg_pkg::MIX_K1;
		end
	end

	// Stage 3: phase offset, quadrant fold to a table address; second hash multiply.
	assign hmix = hmul_s2 ^ (hmul_s2 >> 15);

	always_ff @(posedge clk) begin
		if (en3) begin
			for (int k = 0; k < NT; k++) begin
				logic [31:0]                          phase;
				logic [thg_pkg::SINE_TABLE_BITS-1:0]  idx;
				phase = prod_s2[k] + thg_pkg::PHASE_OFF[k];
				idx   = phase[29 -: thg_pkg::SINE_TABLE_BITS];
				addr_s3[k] <= phase[30]
					? thg_pkg::ADDR_W'(thg_pkg::QSIZE) - thg_pkg::ADDR_W'(idx)
					: thg_pkg::ADDR_W'(idx);
				neg_s3[k]  <= phase[31];
			end
			hmul_s3 <= hmix * thg_pkg::MIX_K2;
		end
	end

	// Stage 4: sine ROM reads; fold the hash by 2^15, which is 1 mod 7.
	for (genvar g = 0; g < NT; g++) begin : g_rom
		thg_sine_rom u_rom (
			.clk  (clk),
			.en   (en4),
			.addr (addr_s3[g]),
			.data (sine_s4[g])
		);
	end

	assign hfin = hmul_s3 ^ (hmul_s3 >> 16);

	always_ff @(posedge clk) begin
		if (en4) begin
			neg_s4  <= neg_s3;
			fold_s4 <= 17'(hfin[14:0]) + 17'(hfin[29:15]) + 17'(hfin[31:30]);
		end
	end

	// Stage 5: weighted sum of the sine terms; finish the mod 7 reduction.
	always_ff @(posedge clk) begin
		if (en5) begin
			logic signed [thg_pkg::SUM_W-1:0] acc;
			logic [thg_pkg::TERM_W-1:0]       term;
			logic [7:0]                       y;
			logic [4:0]                       z;
			logic [3:0]                       w;
			acc = '0;
			for (int k = 0; k < NT; k++) begin
				term = thg_pkg::TERM_W'(thg_pkg::AMP[k]) * thg_pkg::TERM_W'(sine_s4[k]);
				acc  = neg_s4[k] ? acc - thg_pkg::SUM_W'(term) : acc + thg_pkg::SUM_W'(term);
			end
			sum_s5 <= acc;
			y = 8'(fold_s4[5:0]) + 8'(fold_s4[11:6]) + 8'(fold_s4[16:12]);
			z = 5'(y[2:0]) + 5'(y[5:3]) + 5'(y[7:6]);
			w = 4'(z[2:0]) + 4'(z[4:3]);
			rem_s5 <= (w >= 4'd7) ? 3'(w - 4'd7) : 3'(w);
		end
	end

	// Stage 6: integer part toward zero, jitter, clamp.
	always_ff @(posedge clk) begin
		if (en6) begin
			logic [thg_pkg::SUM_W-1:0]            mag;
			logic [thg_pkg::SUM_W-1:0]            whole;
			logic signed [thg_pkg::ROW_CALC_W-1:0] row;
			mag   = sum_s5[thg_pkg::SUM_W-1] ? thg_pkg::SUM_W'(-sum_s5) : thg_pkg::SUM_W'(sum_s5);
			whole = mag >> thg_pkg::FRAC_SHIFT;
			row   = thg_pkg::ROW_CALC_W'(thg_pkg::ROW_BASE) + thg_pkg::ROW_CALC_W'(rem_s5)
				- thg_pkg::ROW_CALC_W'(3);
			row   = sum_s5[thg_pkg::SUM_W-1] ? row - thg_pkg::ROW_CALC_W'(whole)
				: row + thg_pkg::ROW_CALC_W'(whole);
			if (row < thg_pkg::ROW_CALC_W'(thg_pkg::ROW_MIN)) begin
				row = thg_pkg::ROW_CALC_W'(thg_pkg::ROW_MIN);
			end
			if (row > thg_pkg::ROW_CALC_W'(thg_pkg::ROW_MAX)) begin
				row = thg_pkg::ROW_CALC_W'(thg_pkg::ROW_MAX);
			end
			row_s6 <= thg_pkg::ROW_W'(row);
		end
	end

	assign out_valid      = v_s6;
	assign ground_top_row = row_s6;

endmodule

// ===== sv/thg_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Terrain height generator checker
// Port-level properties of the result channel and of pipeline flow.
// ----------------------------------------------------------------------------
module thg_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [thg_pkg::ROW_W-1:0]     ground_top_row
);

	// A stalled result beat keeps its row.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(ground_top_row))
		else $error("result beat changed while stalled");

	// Every delivered row lies inside the clamp window.
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (ground_top_row >= thg_pkg::ROW_W'(thg_pkg::ROW_MIN))
			&& (ground_top_row <= thg_pkg::ROW_W'(thg_pkg::ROW_MAX)))
		else $error("row outside clamp window");

	// With the sink taking beats, the pipeline always moves and takes a column.
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output drains");

endmodule

bind terrain_height_generator_top thg_checker u_thg_checker (.*);
